// ===== design/wtsp_pkg.sv =====
`default_nettype none

package wtsp_pkg;

	// Fixed-point format of coordinates, coefficients and results.
	localparam int FRAC_BITS = 16;
	localparam int COORD_W   = 32;
	localparam int PROD_W    = 2 * COORD_W;
	localparam int NUM_ROWS  = 3;

	// A floored product needs PROD_W - FRAC_BITS bits. Three of them plus a
	// translation need two more bits.
	localparam int CLIP_W    = PROD_W - FRAC_BITS + 2;
	localparam int MAG_W     = CLIP_W - 1;
	localparam int MAG_LO_W  = 32;
	localparam int MAG_HI_W  = MAG_W - MAG_LO_W;

	// Half screen size: a 16-bit pixel count times 2^(FRAC_BITS-1).
	localparam int SIZE_W    = 16;
	localparam int HALF_W    = SIZE_W + FRAC_BITS - 1;
	localparam int NUM_W     = HALF_W + MAG_W;

	// The quotient only matters up to a few bits past the larger of the
	// half size and the output range. Beyond that the result saturates anyway.
	localparam int Q_REACH    = (HALF_W > COORD_W - 1) ? HALF_W : COORD_W - 1;
	localparam int STEP_BITS  = 2;
	localparam int DIV_STAGES = (Q_REACH + 3 + STEP_BITS - 1) / STEP_BITS;
	localparam int QB         = STEP_BITS * DIV_STAGES;
	localparam int SUM_W      = QB + 2;

	localparam int CFG_W      = 64;
	localparam int CFG_IDX_W  = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_ROW_X_A   = 3'd0,
		REG_ROW_X_B   = 3'd1,
		REG_ROW_Y_A   = 3'd2,
		REG_ROW_Y_B   = 3'd3,
		REG_ROW_W_A   = 3'd4,
		REG_ROW_W_B   = 3'd5,
		REG_SCREEN_SZ = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] c0;
		logic signed [COORD_W-1:0] c1;
		logic signed [COORD_W-1:0] c2;
		logic signed [COORD_W-1:0] t;
	} row_t;

	typedef struct packed {
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] w;
	} clip_t;

	typedef struct packed {
		logic             neg;
		logic             ovf;
		logic [CLIP_W-1:0] rem;
		logic [QB-1:0]     bits;
	} div_lane_t;

	typedef struct packed {
		div_lane_t         x;
		div_lane_t         y;
		logic [CLIP_W-1:0] w;
		logic              vis;
	} div_item_t;

endpackage

`default_nettype wire

// ===== design/world_to_screen_projection_core.sv =====
`default_nettype none

// Channel   Direction  Handshake               Payload
// input     in         in_valid / in_stall     pos_x, pos_y, pos_z
// output    out        out_valid / out_stall   screen_x, screen_y, visible
// config    in         wr_en (no handshake)    wr_index, wr_data
//
// One beat is accepted per clock while no stall holds the pipeline; a point passes
// 2 matrix stages, 4 scaling stages, 17 divider stages and 1 output register.
// The divider sets the depth: it resolves two quotient bits per stage.
// Reset clears every valid bit and all configuration registers to zero.
// A stall at the output only holds stages that carry a beat; empty stages
// keep filling, so the input keeps taking beats until the pipeline is full.

module world_to_screen_projection_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_x,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_y,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_z,
	output logic                                out_valid,
	input  logic                                out_stall,
	output logic signed [wtsp_pkg::COORD_W-1:0] screen_x,
	output logic signed [wtsp_pkg::COORD_W-1:0] screen_y,
	output logic                                visible,
	input  logic                                wr_en,
	input  logic [wtsp_pkg::CFG_IDX_W-1:0]      wr_index,
	input  logic [wtsp_pkg::CFG_W-1:0]          wr_data
);
	import wtsp_pkg::*;

	// Matrix rows, each held as the two packed 64-bit words of the register map.
	logic [CFG_W-1:0]      row_x_a_q, row_x_b_q;
	logic [CFG_W-1:0]      row_y_a_q, row_y_b_q;
	logic [CFG_W-1:0]      row_w_a_q, row_w_b_q;
	logic [2*SIZE_W-1:0]   screen_size_q;

	row_t                  row_x, row_y, row_w;
	logic [HALF_W-1:0]     half_w, half_h;

	logic                  dot_ready, dot_valid;
	clip_t                 dot_clip;
	logic                  scl_ready, scl_valid;
	div_item_t             scl_item;
	logic                  div_ready, div_valid;
	div_item_t             div_item;
	logic                  out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_x_a_q     <= '0;
			row_x_b_q     <= '0;
			row_y_a_q     <= '0;
			row_y_b_q     <= '0;
			row_w_a_q     <= '0;
			row_w_b_q     <= '0;
			screen_size_q <= '0;
		end else if (wr_en) begin
			case (reg_idx_t'(wr_index))
				REG_ROW_X_A:   row_x_a_q     <= wr_data;
				REG_ROW_X_B:   row_x_b_q     <= wr_data;
				REG_ROW_Y_A:   row_y_a_q     <= wr_data;
				REG_ROW_Y_B:   row_y_b_q     <= wr_data;
				REG_ROW_W_A:   row_w_a_q     <= wr_data;
				REG_ROW_W_B:   row_w_b_q     <= wr_data;
				REG_SCREEN_SZ: screen_size_q <= wr_data[2*SIZE_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// The first word of a row holds coefficients one and two, the second word
	// holds coefficient three and the translation, low half first.
	assign row_x = {row_x_a_q[COORD_W-1:0], row_x_a_q[CFG_W-1:COORD_W],
		row_x_b_q[COORD_W-1:0], row_x_b_q[CFG_W-1:COORD_W]};
	assign row_y = {row_y_a_q[COORD_W-1:0], row_y_a_q[CFG_W-1:COORD_W],
		row_y_b_q[COORD_W-1:0], row_y_b_q[CFG_W-1:COORD_W]};
	assign row_w = {row_w_a_q[COORD_W-1:0], row_w_a_q[CFG_W-1:COORD_W],
		row_w_b_q[COORD_W-1:0], row_w_b_q[CFG_W-1:COORD_W]};

	// Half the screen size in pixels, in the fixed-point format.
	assign half_w = {screen_size_q[SIZE_W-1:0], {(FRAC_BITS-1){1'b0}}};
	assign half_h = {screen_size_q[2*SIZE_W-1:SIZE_W], {(FRAC_BITS-1){1'b0}}};

	assign in_stall = !dot_ready;

	// Stages one and two: the nine products, then the three clip sums.
	wtsp_dot u_dot (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.pos_x    (pos_x),
		.pos_y    (pos_y),
		.pos_z    (pos_z),
		.row_x    (row_x),
		.row_y    (row_y),
		.row_w    (row_w),
		.dn_ready (scl_ready),
		.up_ready (dot_ready),
		.out_valid(dot_valid),
		.clip     (dot_clip)
	);

	// Stages three to six: sign and magnitude, half size times magnitude,
	// and the overflow test that starts the division.
	wtsp_scale u_scale (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (dot_valid),
		.clip     (dot_clip),
		.half_w   (half_w),
		.half_h   (half_h),
		.dn_ready (div_ready),
		.up_ready (scl_ready),
		.out_valid(scl_valid),
		.item     (scl_item)
	);

	// Both ratios divide by the same w in two parallel lanes.
	wtsp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (scl_valid),
		.in_item  (scl_item),
		.dn_ready (out_ready),
		.up_ready (div_ready),
		.out_valid(div_valid),
		.out_item (div_item)
	);

	// Final add around the screen center, saturation, and the output register.
	wtsp_out u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (div_valid),
		.item     (div_item),
		.half_w   (half_w),
		.half_h   (half_h),
		.out_stall(out_stall),
		.up_ready (out_ready),
		.out_valid(out_valid),
		.screen_x (screen_x),
		.screen_y (screen_y),
		.visible  (visible)
	);

endmodule

`default_nettype wire

// ===== design/wtsp_dot.sv =====
`default_nettype none

module wtsp_dot (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_x,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_y,
	input  logic signed [wtsp_pkg::COORD_W-1:0] pos_z,
	input  wtsp_pkg::row_t                    row_x,
	input  wtsp_pkg::row_t                    row_y,
	input  wtsp_pkg::row_t                    row_w,
	input  logic                              dn_ready,
	output logic                              up_ready,
	output logic                              out_valid,
	output wtsp_pkg::clip_t                   clip
);
	import wtsp_pkg::*;

	row_t                     rows [NUM_ROWS];
	logic signed [PROD_W-1:0] prod_s1 [NUM_ROWS][3];
	logic signed [CLIP_W-1:0] sum [NUM_ROWS];
	logic                     valid_s1;
	logic                     valid_s2;
	clip_t                    clip_s2;
	logic                     en_s1;
	logic                     en_s2;

	assign rows[0] = row_x;
	assign rows[1] = row_y;
	assign rows[2] = row_w;

	assign en_s2    = !valid_s2 || dn_ready;
	assign en_s1    = !valid_s1 || en_s2;
	assign up_ready = en_s1;

	// Each product is floored by the arithmetic shift; the sum is exact.
	always_comb begin
		for (int r = 0; r < NUM_ROWS; r++) begin
			sum[r] = CLIP_W'(prod_s1[r][0] >>> FRAC_BITS)
				+ CLIP_W'(prod_s1[r][1] >>> FRAC_BITS)
				+ CLIP_W'(prod_s1[r][2] >>> FRAC_BITS)
				+ CLIP_W'(rows[r].t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (en_s1) begin
				valid_s1 <= in_valid;
			end
			if (en_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s1 && in_valid) begin
			for (int r = 0; r < NUM_ROWS; r++) begin
				prod_s1[r][0] <= $signed(rows[r].c0) * $signed(pos_x);
				prod_s1[r][1] <= $signed(rows[r].c1) * $signed(pos_y);
				prod_s1[r][2] <= $signed(rows[r].c2) * $signed(pos_z);
			end
		end
		if (en_s2 && valid_s1) begin
			clip_s2.cx <= sum[0];
			clip_s2.cy <= sum[1];
			clip_s2.w  <= sum[2];
		end
	end

	assign out_valid = valid_s2;
	assign clip      = clip_s2;

endmodule

`default_nettype wire

// ===== design/wtsp_scale.sv =====
`default_nettype none

module wtsp_scale (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  wtsp_pkg::clip_t                clip,
	input  logic [wtsp_pkg::HALF_W-1:0]    half_w,
	input  logic [wtsp_pkg::HALF_W-1:0]    half_h,
	input  logic                           dn_ready,
	output logic                           up_ready,
	output logic                           out_valid,
	output wtsp_pkg::div_item_t            item
);
	import wtsp_pkg::*;

	localparam int PLO_W = HALF_W + MAG_LO_W;
	localparam int PHI_W = HALF_W + MAG_HI_W;
	localparam int TOP_W = NUM_W - QB;

	logic              valid_s3, valid_s4, valid_s5, valid_s6;
	logic              en_s3, en_s4, en_s5, en_s6;
	logic              vis_s3, negx_s3, negy_s3;
	logic [MAG_W-1:0]  magx_s3, magy_s3;
	logic [CLIP_W-1:0] w_s3;
	logic              vis_s4, negx_s4, negy_s4;
	logic [PLO_W-1:0]  plox_s4, ploy_s4;
	logic [PHI_W-1:0]  phix_s4, phiy_s4;
	logic [CLIP_W-1:0] w_s4;
	logic              vis_s5, negx_s5, negy_s5;
	logic [NUM_W-1:0]  numx_s5, numy_s5;
	logic [CLIP_W-1:0] w_s5;
	div_item_t         item_s6;

	function automatic div_lane_t init_lane(logic [NUM_W-1:0] num, logic [CLIP_W-1:0] d,
		logic neg);
		div_lane_t l;
		l.neg  = neg;
		l.ovf  = {{(CLIP_W - TOP_W){1'b0}}, num[NUM_W-1:QB]} >= d;
		l.rem  = l.ovf ? '0 : {{(CLIP_W - TOP_W){1'b0}}, num[NUM_W-1:QB]};
		l.bits = num[QB-1:0];
		return l;
	endfunction

	assign en_s6    = !valid_s6 || dn_ready;
	assign en_s5    = !valid_s5 || en_s6;
	assign en_s4    = !valid_s4 || en_s5;
	assign en_s3    = !valid_s3 || en_s4;
	assign up_ready = en_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (en_s3) begin
				valid_s3 <= in_valid;
			end
			if (en_s4) begin
				valid_s4 <= valid_s3;
			end
			if (en_s5) begin
				valid_s5 <= valid_s4;
			end
			if (en_s6) begin
				valid_s6 <= valid_s5;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_s3 && in_valid) begin
			vis_s3  <= clip.w > 0;
			negx_s3 <= clip.cx < 0;
			negy_s3 <= clip.cy < 0;
			magx_s3 <= clip.cx[CLIP_W-1] ? MAG_W'(-clip.cx) : MAG_W'(clip.cx);
			magy_s3 <= clip.cy[CLIP_W-1] ? MAG_W'(-clip.cy) : MAG_W'(clip.cy);
			w_s3    <= clip.w;
		end
		// The wide product is split into two partial products.
		if (en_s4 && valid_s3) begin
			vis_s4  <= vis_s3;
			negx_s4 <= negx_s3;
			negy_s4 <= negy_s3;
			plox_s4 <= PLO_W'(half_w) * PLO_W'(magx_s3[MAG_LO_W-1:0]);
			phix_s4 <= PHI_W'(half_w) * PHI_W'(magx_s3[MAG_W-1:MAG_LO_W]);
			ploy_s4 <= PLO_W'(half_h) * PLO_W'(magy_s3[MAG_LO_W-1:0]);
			phiy_s4 <= PHI_W'(half_h) * PHI_W'(magy_s3[MAG_W-1:MAG_LO_W]);
			w_s4    <= w_s3;
		end
		if (en_s5 && valid_s4) begin
			vis_s5  <= vis_s4;
			negx_s5 <= negx_s4;
			negy_s5 <= negy_s4;
			numx_s5 <= NUM_W'(plox_s4) + (NUM_W'(phix_s4) << MAG_LO_W);
			numy_s5 <= NUM_W'(ploy_s4) + (NUM_W'(phiy_s4) << MAG_LO_W);
			w_s5    <= w_s4;
		end
		if (en_s6 && valid_s5) begin
			item_s6.x   <= init_lane(numx_s5, w_s5, negx_s5);
			item_s6.y   <= init_lane(numy_s5, w_s5, negy_s5);
			item_s6.w   <= w_s5;
			item_s6.vis <= vis_s5;
		end
	end

	assign out_valid = valid_s6;
	assign item      = item_s6;

endmodule

`default_nettype wire

// ===== design/wtsp_div.sv =====
`default_nettype none

module wtsp_div (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	input  wtsp_pkg::div_item_t in_item,
	input  logic                dn_ready,
	output logic                up_ready,
	output logic                out_valid,
	output wtsp_pkg::div_item_t out_item
);
	import wtsp_pkg::*;

	div_item_t item_sd  [DIV_STAGES];
	div_item_t next_item [DIV_STAGES];
	logic      valid_sd [DIV_STAGES];
	logic      en_sd    [DIV_STAGES];

	// Restoring division, STEP_BITS quotient bits per stage. The low dividend
	// bits shift out of the top of bits while quotient bits shift in below.
	function automatic div_lane_t div_step(div_lane_t l, logic [CLIP_W-1:0] d);
		div_lane_t   r;
		logic [CLIP_W:0] t;
		logic        qbit;
		r = l;
		for (int i = 0; i < STEP_BITS; i++) begin
			t    = {r.rem, r.bits[QB-1]};
			qbit = t >= {1'b0, d};
			if (qbit) begin
				r.rem = CLIP_W'(t - {1'b0, d});
			end else begin
				r.rem = t[CLIP_W-1:0];
			end
			r.bits = {r.bits[QB-2:0], qbit};
		end
		return r;
	endfunction

	always_comb begin
		en_sd[DIV_STAGES-1] = !valid_sd[DIV_STAGES-1] || dn_ready;
		for (int i = DIV_STAGES - 2; i >= 0; i--) begin
			en_sd[i] = !valid_sd[i] || en_sd[i+1];
		end
		next_item[0] = in_item;
		for (int i = 1; i < DIV_STAGES; i++) begin
			next_item[i] = item_sd[i-1];
		end
		for (int i = 0; i < DIV_STAGES; i++) begin
			next_item[i].x = div_step(next_item[i].x, next_item[i].w);
			next_item[i].y = div_step(next_item[i].y, next_item[i].w);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIV_STAGES; i++) begin
				valid_sd[i] <= 1'b0;
			end
		end else begin
			if (en_sd[0]) begin
				valid_sd[0] <= in_valid;
			end
			for (int i = 1; i < DIV_STAGES; i++) begin
				if (en_sd[i]) begin
					valid_sd[i] <= valid_sd[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en_sd[0] && in_valid) begin
			item_sd[0] <= next_item[0];
		end
		for (int i = 1; i < DIV_STAGES; i++) begin
			if (en_sd[i] && valid_sd[i-1]) begin
				item_sd[i] <= next_item[i];
			end
		end
	end

	assign up_ready  = en_sd[0];
	assign out_valid = valid_sd[DIV_STAGES-1];
	assign out_item  = item_sd[DIV_STAGES-1];

endmodule

`default_nettype wire

// ===== design/wtsp_out.sv =====
`default_nettype none

module wtsp_out (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  wtsp_pkg::div_item_t               item,
	input  logic [wtsp_pkg::HALF_W-1:0]       half_w,
	input  logic [wtsp_pkg::HALF_W-1:0]       half_h,
	input  logic                              out_stall,
	output logic                              up_ready,
	output logic                              out_valid,
	output logic signed [wtsp_pkg::COORD_W-1:0] screen_x,
	output logic signed [wtsp_pkg::COORD_W-1:0] screen_y,
	output logic                              visible
);
	import wtsp_pkg::*;

	logic                      valid_q;
	logic                      en_q;
	logic signed [SUM_W-1:0]   sum_x;
	logic signed [SUM_W-1:0]   sum_y;
	logic signed [COORD_W-1:0] sx_q;
	logic signed [COORD_W-1:0] sy_q;
	logic                      vis_q;

	function automatic logic signed [SUM_W-1:0] signed_q(div_lane_t l);
		logic [QB-1:0] q;
		q = l.ovf ? {QB{1'b1}} : l.bits;
		return l.neg ? -$signed(SUM_W'(q)) : $signed(SUM_W'(q));
	endfunction

	function automatic logic signed [COORD_W-1:0] sat(logic signed [SUM_W-1:0] v);
		logic signed [SUM_W-1:0] hi;
		logic signed [SUM_W-1:0] lo;
		hi = SUM_W'({1'b0, {(COORD_W-1){1'b1}}});
		lo = -hi - SUM_W'(1);
		if (v > hi) begin
			return hi[COORD_W-1:0];
		end else if (v < lo) begin
			return lo[COORD_W-1:0];
		end
		return v[COORD_W-1:0];
	endfunction

	assign sum_x = $signed(SUM_W'(half_w)) + signed_q(item.x);
	assign sum_y = $signed(SUM_W'(half_h)) - signed_q(item.y);

	assign en_q     = !valid_q || !out_stall;
	assign up_ready = en_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en_q) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en_q && in_valid) begin
			vis_q <= item.vis;
			sx_q  <= item.vis ? sat(sum_x) : '0;
			sy_q  <= item.vis ? sat(sum_y) : '0;
		end
	end

	assign out_valid = valid_q;
	assign screen_x  = sx_q;
	assign screen_y  = sy_q;
	assign visible   = vis_q;

endmodule

`default_nettype wire
